### rtl/core/hotkey_chord_profile_switcher_macros.svh
// Assertion macros used by the hotkey chord profile switcher top level.
`ifndef HOTKEY_CHORD_PROFILE_SWITCHER_MACROS_SVH
`define HOTKEY_CHORD_PROFILE_SWITCHER_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define HCPS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Invariant checked at every rising edge outside reset.
`define HCPS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

### rtl/core/hcps_pkg.sv
// Types and constants of the hotkey chord profile switcher.
package hcps_pkg;

   localparam int CTL_W      = 32;
   localparam int MOD_W      = 6;
   localparam int SEL_TBL_W  = 40;
   localparam int SEL_W      = 5;
   localparam int PROF_W     = 3;
   localparam int SEQ_W      = 31;
   localparam int TID_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;
   localparam int MAX_PROFILES = 8;

   localparam logic [TID_W-1:0]     ID_FLAG  = 32'h8000_0000;
   localparam logic [SEQ_W-1:0]     SEQ_MAX  = 31'h7fff_ffff;
   localparam logic [SEQ_W-1:0]     SEQ_INIT = 31'd1;
   localparam logic [MOD_W-1:0]     MOD_NONE = 6'd32;
   localparam logic [SEL_TBL_W-1:0] SEL_TBL_INIT = 40'hff_ffff_ffff;

   localparam logic [CSR_IDX_W-1:0] CSR_MODIFIER      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECTOR_TBL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_CHORD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTION_CHORD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_CYCLE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_MOTION    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PROF   = 3'd6;

   // Chord detection result for one sample.
   typedef struct packed {
      logic [CTL_W-1:0]  selectors;
      logic [CTL_W-1:0]  pressed;
      logic [CTL_W-1:0]  modifier;
      logic [CTL_W-1:0]  chord;
      logic [CTL_W-1:0]  consumed;
      logic              direct;
      logic              cycle;
      logic              motion;
      logic              multi;
      logic [PROF_W-1:0] direct_target;
   } det_type;

endpackage

### rtl/core/hcps_req_if.sv
// Request channel: one controller sample per beat.
interface hcps_req_if
   import hcps_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             action;
   logic [CTL_W-1:0] controls;
   logic             service_busy;

   modport source (output valid, action, controls, service_busy, input ready);
   modport sink   (input valid, action, controls, service_busy, output ready);
endinterface

### rtl/core/hcps_rsp_if.sv
// Response channel: one result per sample beat.
interface hcps_rsp_if
   import hcps_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CTL_W-1:0]  consumed;
   logic              activate;
   logic [PROF_W-1:0] target_profile;
   logic [TID_W-1:0]  txn_id;
   logic              toggle_motion;

   modport source (output valid, consumed, activate, target_profile, txn_id,
                   toggle_motion, input ready);
   modport sink   (input valid, consumed, activate, target_profile, txn_id,
                   toggle_motion, output ready);
endinterface

### rtl/core/hcps_detect.sv
// Chord detection: selector set, modifier, chord matches and consumed mask.
module hcps_detect
   import hcps_pkg::*;
#(
   parameter int PROFILE_COUNT = 8,
   parameter int BUTTON_COUNT  = 16,
   parameter int CONTROL_COUNT = 32
) (
   input  logic [CTL_W-1:0]     controls,
   input  logic [MOD_W-1:0]     modifier_index,
   input  logic [SEL_TBL_W-1:0] selector_table,
   input  logic [CTL_W-1:0]     cyc_cfg,
   input  logic [CTL_W-1:0]     mot_cfg,
   input  logic [CTL_W-1:0]     cyc_dflt,
   input  logic [CTL_W-1:0]     mot_dflt,
   output det_type              det
);

   localparam int NPROF = (PROFILE_COUNT < MAX_PROFILES) ? PROFILE_COUNT : MAX_PROFILES;

   logic [SEL_W-1:0] sel;
   logic [CTL_W-1:0] cyc;
   logic [CTL_W-1:0] mot;

   always_comb begin
      det = '0;
      sel = '0;
      for (int p = 0; p < NPROF; p++) begin
         sel = selector_table[SEL_W*p +: SEL_W];
         if (sel < SEL_W'(BUTTON_COUNT)) begin
            det.selectors[sel[3:0]] = 1'b1;
         end
      end
      if (modifier_index < MOD_W'(CONTROL_COUNT)) begin
         det.modifier = CTL_W'(1) << modifier_index[4:0];
      end
      det.pressed = controls & det.selectors;
      det.direct  = ((controls & det.modifier) != '0) && (det.pressed != '0);
      det.multi   = (det.pressed & (det.pressed - CTL_W'(1))) != '0;

      cyc = (cyc_cfg != '0) ? cyc_cfg : cyc_dflt;
      mot = (mot_cfg != '0) ? mot_cfg : mot_dflt;
      det.cycle  = (cyc != '0) && ((controls & cyc) == cyc);
      det.motion = (mot != '0) && ((controls & mot) == mot);

      det.consumed = (det.direct ? (det.modifier | det.pressed) : '0) |
                     (det.cycle ? cyc : '0) | (det.motion ? mot : '0);
      det.chord = det.direct ? (det.modifier | det.pressed) : det.cycle ? cyc : mot;

      // lowest table position whose button is pressed wins
      for (int p = NPROF - 1; p >= 0; p--) begin
         sel = selector_table[SEL_W*p +: SEL_W];
         if (sel < SEL_W'(BUTTON_COUNT) && det.pressed[sel[3:0]]) begin
            det.direct_target = PROF_W'(p);
         end
      end
   end

endmodule

### rtl/core/hotkey_chord_profile_switcher.sv
// Hotkey chord profile switcher top level.
//
// req_ch carries one controller sample per beat (action, controls,
// service_busy); rsp_ch returns exactly one result beat per sample
// (consumed, activate, target_profile, txn_id, toggle_motion).
// Both use valid/ready; a beat moves when both are high.
// The csr_ port writes one register per cycle with csr_we high; write
// only while no sample is in flight.
// An accepted sample passes the input register and then the result
// register before it shows on rsp_ch. Throughput: one sample per cycle
// while rsp_ch does not stall. A sample sits in the input register, chord
// logic and the state update run in the cycle that moves it into the
// result register, so the next sample sees the updated state. When rsp_ch
// stalls, the result register holds and one more sample is taken into
// the input register; req_ch.ready then drops until the result drains.
// Reset (synchronous, active high) empties both registers, loads the
// register defaults and returns the chord state to idle with the
// transaction sequence at 1.
module hotkey_chord_profile_switcher
   import hcps_pkg::*;
#(
   parameter int PROFILE_COUNT = 8,
   parameter int BUTTON_COUNT  = 16,
   parameter int CONTROL_COUNT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   hcps_req_if.sink              req_ch,
   hcps_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "hotkey_chord_profile_switcher_macros.svh"

   localparam logic [PROF_W:0] PROF_CNT = (PROF_W+1)'(PROFILE_COUNT);

   // configuration
   logic [MOD_W-1:0]     mod_idx_ff;
   logic [SEL_TBL_W-1:0] sel_tbl_ff;
   logic [CTL_W-1:0]     cyc_chord_ff;
   logic [CTL_W-1:0]     mot_chord_ff;
   logic [CTL_W-1:0]     def_cyc_ff;
   logic [CTL_W-1:0]     def_mot_ff;
   logic [PROF_W-1:0]    active_ff;

   // input register
   logic             in_vld_ff;
   logic             in_act_ff;
   logic [CTL_W-1:0] in_ctl_ff;
   logic             in_busy_ff;

   // chord state
   logic [CTL_W-1:0]  held_ff, held_in;
   logic [CTL_W-1:0]  rel_ff, rel_in;
   logic [CTL_W-1:0]  hsel_ff, hsel_in;
   logic              rd_ff, rd_in;
   logic [PROF_W-1:0] tgt_ff, tgt_in;
   logic [TID_W-1:0]  cur_ff, cur_in;
   logic [CTL_W-1:0]  prev_ff;
   logic [SEQ_W-1:0]  seq_ff, seq_in;

   // result register
   logic              out_vld_ff;
   logic [CTL_W-1:0]  out_cons_ff, out_cons_in;
   logic              out_act_ff, out_act_in;
   logic [PROF_W-1:0] out_tgt_ff, out_tgt_in;
   logic [TID_W-1:0]  out_tid_ff, out_tid_in;
   logic              out_tog_ff, out_tog_in;

   logic              advance;
   logic              req_fire;
   det_type           det;
   logic [CTL_W-1:0]  prev;
   logic [CTL_W-1:0]  part;
   logic              released;
   logic              finished;
   logic              do_try;
   logic              go;
   logic [PROF_W:0]   next_sum;
   logic [PROF_W-1:0] next_prof;

   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   hcps_detect #(
      .PROFILE_COUNT (PROFILE_COUNT),
      .BUTTON_COUNT  (BUTTON_COUNT),
      .CONTROL_COUNT (CONTROL_COUNT)
   ) u_detect (
      .controls       (in_ctl_ff),
      .modifier_index (mod_idx_ff),
      .selector_table (sel_tbl_ff),
      .cyc_cfg        (cyc_chord_ff),
      .mot_cfg        (mot_chord_ff),
      .cyc_dflt       (def_cyc_ff),
      .mot_dflt       (def_mot_ff),
      .det            (det)
   );

   // (active + 1) mod PROFILE_COUNT; the sum is at most 8, so a few subtracts do
   always_comb begin
      next_sum = {1'b0, active_ff} + (PROF_W+1)'(1);
      for (int i = 0; i < 4; i++) begin
         if (next_sum >= PROF_CNT) begin
            next_sum = next_sum - PROF_CNT;
         end
      end
      next_prof = next_sum[PROF_W-1:0];
   end

   always_comb begin
      rd_in   = in_act_ff ? 1'b1 : rd_ff;
      cur_in  = in_act_ff ? '0 : cur_ff;
      prev    = in_act_ff ? in_ctl_ff : prev_ff;
      held_in = held_ff;
      rel_in  = rel_ff;
      hsel_in = hsel_ff;
      tgt_in  = tgt_ff;
      seq_in  = seq_ff;
      part    = held_ff & ~hsel_ff;
      released = 1'b0;
      finished = 1'b0;
      do_try   = 1'b0;
      go       = 1'b0;
      out_cons_in = det.consumed;
      out_act_in  = 1'b0;
      out_tgt_in  = '0;
      out_tid_in  = '0;
      out_tog_in  = 1'b0;

      if (held_ff != '0) begin
         out_cons_in = out_cons_in | held_ff | (in_ctl_ff & hsel_ff);
         if (hsel_ff != '0) begin
            released = ((in_ctl_ff & rel_ff) == '0) ||
                       !((part != '0) && ((in_ctl_ff & part) == part));
         end else begin
            released = (in_ctl_ff & held_ff) != held_ff;
         end
         if (released) begin
            held_in = '0;
            rel_in  = '0;
            hsel_in = '0;
            rd_in   = 1'b1;
            cur_in  = '0;
         end else begin
            if ((in_ctl_ff & held_ff) == held_ff) begin
               do_try = 1'b1;
            end else begin
               rd_in = 1'b1;
            end
            finished = 1'b1;
         end
      end

      if (!finished && (det.direct || det.cycle || det.motion)) begin
         held_in = det.chord;
         rel_in  = det.direct ? det.pressed : det.chord;
         hsel_in = det.direct ? det.selectors : '0;
         rd_in   = 1'b1;
         // fresh press only: chord not fully held on the previous sample
         if ((prev & det.chord) != det.chord) begin
            go = 1'b1;
            if (det.direct) begin
               if (det.multi) begin
                  go = 1'b0;
               end else begin
                  tgt_in = det.direct_target;
               end
            end else if (det.cycle) begin
               tgt_in = next_prof;
            end else begin
               out_tog_in = 1'b1;
               go = 1'b0;
            end
            if (go) begin
               rd_in  = 1'b0;
               cur_in = ID_FLAG | TID_W'(seq_ff);
               seq_in = (seq_ff >= SEQ_MAX) ? SEQ_INIT : seq_ff + SEQ_INIT;
               do_try = 1'b1;
            end
         end
      end

      if (do_try && !rd_in) begin
         if (tgt_in == active_ff) begin
            rd_in = 1'b1;
         end else begin
            out_act_in = 1'b1;
            out_tgt_in = tgt_in;
            out_tid_in = cur_in;
            if (!in_busy_ff) begin
               rd_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         mod_idx_ff   <= MOD_NONE;
         sel_tbl_ff   <= SEL_TBL_INIT;
         cyc_chord_ff <= '0;
         mot_chord_ff <= '0;
         def_cyc_ff   <= '0;
         def_mot_ff   <= '0;
         active_ff    <= '0;
         held_ff      <= '0;
         rel_ff       <= '0;
         hsel_ff      <= '0;
         rd_ff        <= 1'b1;
         tgt_ff       <= '0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         seq_ff       <= SEQ_INIT;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODIFIER:     mod_idx_ff   <= csr_wdata[MOD_W-1:0];
               CSR_SELECTOR_TBL: sel_tbl_ff   <= csr_wdata[SEL_TBL_W-1:0];
               CSR_CYCLE_CHORD:  cyc_chord_ff <= csr_wdata[CTL_W-1:0];
               CSR_MOTION_CHORD: mot_chord_ff <= csr_wdata[CTL_W-1:0];
               CSR_DEF_CYCLE:    def_cyc_ff   <= csr_wdata[CTL_W-1:0];
               CSR_DEF_MOTION:   def_mot_ff   <= csr_wdata[CTL_W-1:0];
               CSR_ACTIVE_PROF:  active_ff    <= csr_wdata[PROF_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
            held_ff    <= held_in;
            rel_ff     <= rel_in;
            hsel_ff    <= hsel_in;
            rd_ff      <= rd_in;
            tgt_ff     <= tgt_in;
            cur_ff     <= cur_in;
            prev_ff    <= in_ctl_ff;
            seq_ff     <= seq_in;
         end else if (rsp_ch.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_act_ff  <= req_ch.action;
         in_ctl_ff  <= req_ch.controls;
         in_busy_ff <= req_ch.service_busy;
      end
      if (advance) begin
         out_cons_ff <= out_cons_in;
         out_act_ff  <= out_act_in;
         out_tgt_ff  <= out_tgt_in;
         out_tid_ff  <= out_tid_in;
         out_tog_ff  <= out_tog_in;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.consumed       = out_cons_ff;
   assign rsp_ch.activate       = out_act_ff;
   assign rsp_ch.target_profile = out_tgt_ff;
   assign rsp_ch.txn_id         = out_tid_ff;
   assign rsp_ch.toggle_motion  = out_tog_ff;

   `HCPS_ASSERT_IMPL(a_issue_id, clock, reset, out_vld_ff && out_act_ff,
      out_tid_ff[TID_W-1] && (out_tgt_ff != active_ff), "issued request lacks id or is a no-op")
   `HCPS_ASSERT_IMPL(a_idle_zero, clock, reset, out_vld_ff && !out_act_ff,
      (out_tid_ff == '0) && (out_tgt_ff == '0), "id or target set without a request")
   `HCPS_ASSERT_ALWAYS(a_seq_nonzero, clock, reset, seq_ff != '0,
      "sequence counter reached zero")
   `HCPS_ASSERT_IMPL(a_held_clear, clock, reset, held_ff == '0,
      (rel_ff == '0) && (hsel_ff == '0), "release state left without a held chord")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hotkey chord profile switcher: directed chords, random mixes.
module tb;
   import hcps_pkg::*;

   localparam int PROFILE_COUNT = 8;
   localparam int BUTTON_COUNT  = 16;
   localparam int CONTROL_COUNT = 32;

   localparam bit ACT_SAMPLE = 1'b0;
   localparam bit ACT_RESYNC = 1'b1;

   typedef struct packed {
      logic [CTL_W-1:0]  consumed;
      logic              activate;
      logic [PROF_W-1:0] target_profile;
      logic [TID_W-1:0]  txn_id;
      logic              toggle_motion;
   } switch_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hcps_req_if req_ch ();
   hcps_rsp_if rsp_ch ();

   hotkey_chord_profile_switcher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [MOD_W-1:0]     cfg_modifier;
   logic [SEL_TBL_W-1:0] cfg_sel_tbl;
   logic [CTL_W-1:0]     cfg_cycle, cfg_motion, cfg_def_cycle, cfg_def_motion;
   logic [PROF_W-1:0]    cfg_active;

   // predictor copy of the chord state
   logic [CTL_W-1:0]  st_held, st_release, st_held_sel, st_txn, st_prev;
   bit                st_done;
   logic [PROF_W-1:0] st_target;
   logic [SEQ_W-1:0]  st_seq;

   switch_result_type pending_results[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  hold_off_cycles = 0;
   bit  no_idle = 1'b0;

   function automatic void reset_model();
      cfg_modifier   = MOD_NONE;
      cfg_sel_tbl    = SEL_TBL_INIT;
      cfg_cycle      = '0;
      cfg_motion     = '0;
      cfg_def_cycle  = '0;
      cfg_def_motion = '0;
      cfg_active     = '0;
      st_held        = '0;
      st_release     = '0;
      st_held_sel    = '0;
      st_done        = 1'b1;
      st_target      = '0;
      st_txn         = '0;
      st_prev        = '0;
      st_seq         = SEQ_INIT;
   endfunction

   function automatic bit mask_all_set(logic [CTL_W-1:0] ctl, logic [CTL_W-1:0] chord);
      return chord != '0 && (ctl & chord) == chord;
   endfunction

   function automatic logic [TID_W-1:0] next_txn_id();
      logic [TID_W-1:0] id;
      id = ID_FLAG | {1'b0, st_seq};
      st_seq = (st_seq >= SEQ_MAX) ? SEQ_INIT : st_seq + 1'b1;
      return id;
   endfunction

   // returns 1 when a request goes out on this sample
   function automatic bit attempt_request(bit busy);
      bit issue;
      issue = 1'b0;
      if (!st_done) begin
         if (st_target == cfg_active) begin
            st_done = 1'b1;
         end else begin
            issue = 1'b1;
            if (!busy) st_done = 1'b1;
         end
      end
      return issue;
   endfunction

   function automatic switch_result_type predict_chord_result(bit act, logic [CTL_W-1:0] ctl,
                                                              bit busy);
      switch_result_type r;
      logic [CTL_W-1:0] sels, mod_m, pressed, cyc, mot, chord;
      logic [SEL_W-1:0] s;
      bit direct, cycle, motion, finished, released, go, found, issue_now;
      int next_prof;
      r = '0;
      sels = '0;
      finished = 1'b0;
      issue_now = 1'b0;
      if (act == ACT_RESYNC) begin
         st_prev = ctl;
         st_done = 1'b1;
         st_txn  = '0;
      end
      for (int p = 0; p < PROFILE_COUNT; p++) begin
         s = cfg_sel_tbl[SEL_W*p +: SEL_W];
         if (s < BUTTON_COUNT) sels[s] = 1'b1;
      end
      mod_m   = (cfg_modifier < CONTROL_COUNT) ? (32'd1 << cfg_modifier) : '0;
      pressed = ctl & sels;
      direct  = (ctl & mod_m) != '0 && pressed != '0;
      cyc     = (cfg_cycle != '0) ? cfg_cycle : cfg_def_cycle;
      mot     = (cfg_motion != '0) ? cfg_motion : cfg_def_motion;
      cycle   = mask_all_set(ctl, cyc);
      motion  = mask_all_set(ctl, mot);
      r.consumed = (direct ? (mod_m | pressed) : '0) | (cycle ? cyc : '0) |
                   (motion ? mot : '0);

      if (st_held != '0) begin
         r.consumed |= st_held | (ctl & st_held_sel);
         if (st_held_sel != '0)
            released = (ctl & st_release) == '0 ||
                       !mask_all_set(ctl, st_held & ~st_held_sel);
         else
            released = !mask_all_set(ctl, st_held);
         if (released) begin
            st_held     = '0;
            st_release  = '0;
            st_held_sel = '0;
            st_done     = 1'b1;
            st_txn      = '0;
         end else begin
            if (mask_all_set(ctl, st_held)) issue_now = attempt_request(busy);
            else st_done = 1'b1;
            finished = 1'b1;
         end
      end

      if (!finished && (direct || cycle || motion)) begin
         chord       = direct ? (mod_m | pressed) : cycle ? cyc : mot;
         st_held     = chord;
         st_release  = direct ? pressed : chord;
         st_held_sel = direct ? sels : '0;
         st_done     = 1'b1;
         if (!mask_all_set(st_prev, chord)) begin
            go = 1'b1;
            if (direct) begin
               if ((pressed & (pressed - 1'b1)) != '0) begin
                  go = 1'b0;
               end else begin
                  found = 1'b0;
                  for (int p = 0; p < PROFILE_COUNT; p++) begin
                     s = cfg_sel_tbl[SEL_W*p +: SEL_W];
                     if (!found && s < BUTTON_COUNT && pressed[s]) begin
                        st_target = p[PROF_W-1:0];
                        found = 1'b1;
                     end
                  end
               end
            end else if (cycle) begin
               next_prof = (int'(cfg_active) + 1) % PROFILE_COUNT;
               st_target = next_prof[PROF_W-1:0];
            end else begin
               r.toggle_motion = 1'b1;
               go = 1'b0;
            end
            if (go) begin
               st_done   = 1'b0;
               st_txn    = next_txn_id();
               issue_now = attempt_request(busy);
            end
         end
      end

      st_prev = ctl;
      if (issue_now) begin
         r.activate       = 1'b1;
         r.target_profile = st_target;
         r.txn_id         = st_txn;
      end
      return r;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d at %0t: %s expected %h got %h", mismatches, $realtime, what,
                  want, got);
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic bit rand_action();
      return ($urandom_range(0, 15) == 0) ? ACT_RESYNC : ACT_SAMPLE;
   endfunction

   function automatic logic [CTL_W-1:0] ctl_bit(int n);
      return 32'd1 << n;
   endfunction

   function automatic logic [CTL_W-1:0] random_mask();
      logic [CTL_W-1:0] m;
      m = '0;
      repeat ($urandom_range(1, 3)) m[$urandom_range(0, 31)] = 1'b1;
      return m;
   endfunction

   function automatic logic [CTL_W-1:0] maybe_mask();
      return ($urandom_range(0, 3) == 0) ? '0 : random_mask();
   endfunction

   function automatic logic [SEL_TBL_W-1:0] ordered_table();
      logic [SEL_TBL_W-1:0] tbl;
      for (int p = 0; p < 8; p++) tbl[SEL_W*p +: SEL_W] = p[SEL_W-1:0];
      return tbl;
   endfunction

   function automatic logic [SEL_TBL_W-1:0] random_table();
      logic [SEL_TBL_W-1:0] tbl;
      for (int p = 0; p < 8; p++)
         tbl[SEL_W*p +: SEL_W] = ($urandom_range(0, 3) == 0) ? SEL_W'($urandom_range(16, 31))
                                                             : SEL_W'($urandom_range(0, 15));
      return tbl;
   endfunction

   function automatic logic [MOD_W-1:0] random_modifier();
      return ($urandom_range(0, 4) == 0) ? MOD_W'($urandom_range(32, 63))
                                         : MOD_W'($urandom_range(0, 31));
   endfunction

   // one sample beat; valid stays up when the next beat follows at once
   task automatic send_sample(bit act, logic [CTL_W-1:0] ctl, bit busy);
      int gap;
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.controls     <= ctl;
      req_ch.service_busy <= busy;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(predict_chord_result(act, ctl, busy));
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      int guard;
      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_results.size() != 0) begin
         note_mismatch("results never returned", pending_results.size(), 0);
         pending_results.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MODIFIER:     cfg_modifier   = data[MOD_W-1:0];
         CSR_SELECTOR_TBL: cfg_sel_tbl    = data[SEL_TBL_W-1:0];
         CSR_CYCLE_CHORD:  cfg_cycle      = data[CTL_W-1:0];
         CSR_MOTION_CHORD: cfg_motion     = data[CTL_W-1:0];
         CSR_DEF_CYCLE:    cfg_def_cycle  = data[CTL_W-1:0];
         CSR_DEF_MOTION:   cfg_def_motion = data[CTL_W-1:0];
         CSR_ACTIVE_PROF:  cfg_active     = data[PROF_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [MOD_W-1:0] m, logic [SEL_TBL_W-1:0] tbl,
                                logic [CTL_W-1:0] cc, logic [CTL_W-1:0] mc,
                                logic [CTL_W-1:0] dc, logic [CTL_W-1:0] dm,
                                logic [PROF_W-1:0] ap);
      settle();
      write_reg(CSR_MODIFIER, CSR_DATA_W'(m));
      write_reg(CSR_SELECTOR_TBL, tbl);
      write_reg(CSR_CYCLE_CHORD, CSR_DATA_W'(cc));
      write_reg(CSR_MOTION_CHORD, CSR_DATA_W'(mc));
      write_reg(CSR_DEF_CYCLE, CSR_DATA_W'(dc));
      write_reg(CSR_DEF_MOTION, CSR_DATA_W'(dm));
      write_reg(CSR_ACTIVE_PROF, CSR_DATA_W'(ap));
      csr_we <= 1'b0;
   endtask

   // press, hold, maybe partly release, then let go of one chord
   task automatic play_chord();
      int kind, p, n;
      logic [SEL_W-1:0] btn;
      logic [CTL_W-1:0] chord, ctl, mod_m;
      mod_m = (cfg_modifier < CONTROL_COUNT) ? (32'd1 << cfg_modifier) : '0;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         p = $urandom_range(0, PROFILE_COUNT - 1);
         btn = cfg_sel_tbl[SEL_W*p +: SEL_W];
         chord = mod_m;
         if (btn < BUTTON_COUNT) chord[btn] = 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            p = $urandom_range(0, PROFILE_COUNT - 1);
            btn = cfg_sel_tbl[SEL_W*p +: SEL_W];
            if (btn < BUTTON_COUNT) chord[btn] = 1'b1;
         end
      end else if (kind < 6) begin
         chord = (cfg_cycle != '0) ? cfg_cycle : cfg_def_cycle;
      end else if (kind < 8) begin
         chord = (cfg_motion != '0) ? cfg_motion : cfg_def_motion;
      end else begin
         chord = $urandom;
      end
      if (chord == '0) chord = $urandom;
      if ($urandom_range(0, 2) == 0)
         send_sample(rand_action(), ctl_bit($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      n = $urandom_range(1, 5);
      repeat (n) begin
         ctl = chord;
         if ($urandom_range(0, 5) == 0) ctl[$urandom_range(0, 31)] = 1'b1;
         if ($urandom_range(0, 7) == 0) ctl[$urandom_range(0, 31)] = 1'b0;
         send_sample(rand_action(), ctl, $urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 3) == 0)
         send_sample(rand_action(), chord & $urandom, 1'($urandom_range(0, 1)));
      send_sample(rand_action(), '0, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_idle_defaults();
      send_sample(ACT_SAMPLE, '0, 1'b0);
      send_sample(ACT_SAMPLE, '1, 1'b1);
      send_sample(ACT_RESYNC, '1, 1'b0);
   endtask

   task automatic test_direct_select();
      logic [CTL_W-1:0] m;
      m = ctl_bit(31);
      load_settings(6'd31, ordered_table(), '0, '0, ctl_bit(20) | ctl_bit(21),
                    ctl_bit(22) | ctl_bit(23), 3'd0);
      send_sample(ACT_SAMPLE, m | ctl_bit(3), 1'b0);
      send_sample(ACT_SAMPLE, m | ctl_bit(3), 1'b0);
      send_sample(ACT_SAMPLE, '0, 1'b0);
      // target equals the active profile
      send_sample(ACT_SAMPLE, m | ctl_bit(0), 1'b0);
      send_sample(ACT_SAMPLE, '0, 1'b0);
      // two selectors at once, then one of them let go
      send_sample(ACT_SAMPLE, m | ctl_bit(1) | ctl_bit(2), 1'b0);
      send_sample(ACT_SAMPLE, m | ctl_bit(1), 1'b0);
      send_sample(ACT_SAMPLE, '0, 1'b0);
      // busy service: request repeats until it goes through
      send_sample(ACT_SAMPLE, m | ctl_bit(5), 1'b1);
      send_sample(ACT_SAMPLE, m | ctl_bit(5), 1'b1);
      send_sample(ACT_SAMPLE, m | ctl_bit(5), 1'b0);
      send_sample(ACT_SAMPLE, m | ctl_bit(5), 1'b0);
      send_sample(ACT_SAMPLE, '0, 1'b0);
      send_sample(ACT_SAMPLE, m | ctl_bit(6), 1'b1);
      send_sample(ACT_SAMPLE, m | ctl_bit(6) | ctl_bit(7), 1'b1);
      send_sample(ACT_SAMPLE, '0, 1'b0);
   endtask

   task automatic test_cycle_motion();
      load_settings(6'd31, ordered_table(), ctl_bit(8) | ctl_bit(9), '0,
                    ctl_bit(20) | ctl_bit(21), ctl_bit(22) | ctl_bit(23), 3'd7);
      // cycle from the last profile wraps to profile 0
      send_sample(ACT_SAMPLE, ctl_bit(8) | ctl_bit(9), 1'b0);
      send_sample(ACT_SAMPLE, '0, 1'b0);
      send_sample(ACT_SAMPLE, ctl_bit(22) | ctl_bit(23), 1'b0);
      send_sample(ACT_RESYNC, ctl_bit(22) | ctl_bit(23), 1'b0);
      send_sample(ACT_SAMPLE, '0, 1'b0);
   endtask

   task automatic test_cleared_chords();
      load_settings(MOD_NONE, SEL_TBL_INIT, '0, '0, '0, '0, 3'd0);
      send_sample(ACT_SAMPLE, '1, 1'b0);
      send_sample(ACT_SAMPLE, '0, 1'b1);
   endtask

   task automatic test_random_mix();
      int start;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_settings(6'd0, '0, '1, '0, '0, random_mask(), 3'd0);
            1: load_settings(6'd63, SEL_TBL_INIT, '0, '1, random_mask(), random_mask(), 3'd7);
            2: load_settings(6'd31, ordered_table(), random_mask(), random_mask(), '0, '0,
                             3'd7);
            default: load_settings(random_modifier(), random_table(), maybe_mask(),
                                   maybe_mask(), maybe_mask(), maybe_mask(),
                                   PROF_W'($urandom_range(0, 7)));
         endcase
         no_idle = (ph == 3);
         start = items_sent;
         while (items_sent < start + 230) begin
            if ($urandom_range(0, 4) == 0)
               send_sample(rand_action(), $urandom, 1'($urandom_range(0, 1)));
            else
               play_chord();
         end
      end
      no_idle = 1'b0;
   endtask

   // sink holds off long enough for the block to fill and drop req ready
   task automatic test_backpressure();
      settle();
      hold_off_cycles = 300;
      no_idle = 1'b1;
      repeat (12) play_chord();
      no_idle = 1'b0;
      settle();
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_SAMPLE;
      req_ch.controls     = '0;
      req_ch.service_busy = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_MODIFIER;
      csr_wdata           = '0;
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_defaults();
      test_direct_select();
      test_cycle_motion();
      test_cleared_chords();
      test_random_mix();
      test_backpressure();
      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // result sink: random ready, steady stretches, one long hold-off on request
   initial begin : result_sink
      int n, r;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (no_idle) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ch.ready <= 1'b1;
            end else if (r < 95) begin
               rsp_ch.ready <= 1'b0;
               repeat ($urandom_range(0, 3)) @(posedge clock);
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      switch_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            note_mismatch("result beat with nothing pending", 0, rsp_ch.consumed);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.consumed !== want.consumed)
               note_mismatch("consumed", want.consumed, rsp_ch.consumed);
            if (rsp_ch.activate !== want.activate)
               note_mismatch("activate", 32'(want.activate), 32'(rsp_ch.activate));
            if (rsp_ch.target_profile !== want.target_profile)
               note_mismatch("target_profile", 32'(want.target_profile),
                             32'(rsp_ch.target_profile));
            if (rsp_ch.txn_id !== want.txn_id)
               note_mismatch("txn_id", want.txn_id, rsp_ch.txn_id);
            if (rsp_ch.toggle_motion !== want.toggle_motion)
               note_mismatch("toggle_motion", 32'(want.toggle_motion),
                             32'(rsp_ch.toggle_motion));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
